### hdl/rtp_jpeg_packetizer_top_assert.svh
// ---------------------------------------------------------------------------
// rtp_jpeg_packetizer_top_assert.svh
// Assertion macros for the packetizer checker
// ---------------------------------------------------------------------------
`ifndef RTP_JPEG_PACKETIZER_TOP_ASSERT_SVH
`define RTP_JPEG_PACKETIZER_TOP_ASSERT_SVH

// same-cycle implication, quiet during reset
`define RJP_ASSERT_NOW(label, pre, post, clk, rstn) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |-> (post)) \
    else $error("rjp assertion failed: same-cycle rule");

// next-cycle implication, quiet during reset
`define RJP_ASSERT_NEXT(label, pre, post, clk, rstn) \
  label: assert property (@(posedge clk) disable iff (!rstn) (pre) |=> (post)) \
    else $error("rjp assertion failed: next-cycle rule");

`endif

### hdl/rjp_pkg.sv
// ---------------------------------------------------------------------------
// rjp_pkg
// Shared types and constants of the RTP/JPEG packetizer
// ---------------------------------------------------------------------------
package rjp_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    Cfg_Max_Fragment   = 3'd0,
    Cfg_Tcp_Interleave = 3'd1,
    Cfg_Width_Blocks   = 3'd2,
    Cfg_Height_Blocks  = 3'd3,
    Cfg_Ts_Step        = 3'd4,
    Cfg_Ssrc           = 3'd5,
    Cfg_Quality        = 3'd6,
    Cfg_Jpeg_Type      = 3'd7
  } cfg_index_e;

  // register reset values
  localparam logic [10:0] Max_Fragment_Rst = 11'd1100;
  localparam logic        Tcp_Rst          = 1'b0;
  localparam logic [7:0]  Width_Rst        = 8'd80;
  localparam logic [7:0]  Height_Rst       = 8'd60;
  localparam logic [16:0] Ts_Step_Rst      = 17'd9000;
  localparam logic [31:0] Ssrc_Rst         = 32'h13f9_7e67;
  localparam logic [7:0]  Quality_Rst      = 8'h5e;
  localparam logic [7:0]  Jpeg_Type_Rst    = 8'h01;

  // header constants
  localparam logic [7:0]  Interleave_Magic = 8'h24;  // '$'
  localparam logic [7:0]  Rtp_First_Byte   = 8'h80;  // version 2
  localparam logic [6:0]  Rtp_Payload_Type = 7'h1a;  // JPEG
  localparam logic [11:0] Hdr_Overhead     = 12'd20; // RTP + JPEG headers

  // header byte positions; the prefix occupies 0..3, payload follows 23
  localparam logic [4:0]  Pos_Rtp_Start    = 5'd4;
  localparam logic [4:0]  Pos_Payload      = 5'd24;

  typedef struct packed {
    logic [10:0] max_fragment;
    logic        tcp_interleaved;
    logic [7:0]  width_blocks;
    logic [7:0]  height_blocks;
    logic [16:0] timestamp_step;
    logic [31:0] ssrc;
    logic [7:0]  quality_factor;
    logic [7:0]  jpeg_type;
  } cfg_t;

  // one byte handed from the core to the output register
  typedef struct packed {
    logic       valid;
    logic [7:0] out_byte;
    logic       packet_end;
    logic       item_end;
  } emit_t;

endpackage

### hdl/rtp_jpeg_packetizer_top.sv
// ---------------------------------------------------------------------------
// rtp_jpeg_packetizer_top
// RTP/JPEG packetizer: cuts JPEG scan bytes into packets with headers
// ---------------------------------------------------------------------------
//  channel  dir  handshake               payload
//  in       in   in_valid_i/in_ready_o   jpeg_byte_i, frame_length_i
//  out      out  out_valid_o/out_ready_i out_byte_o, packet_end_o, item_end_o
//  cfg      in   cfg_valid_i/cfg_ready_o cfg_index_i, cfg_data_i
//
//  a byte inside a fragment is emitted on its own; the first byte of a fragment
//  follows the RTP and JPEG headers, and the interleaved prefix when enabled,
//  one header byte per cycle through the output register unless it stalls.
//  reset clears the packet state and loads register defaults.
//  an output stall holds the output register and backs up into the input.
// ---------------------------------------------------------------------------
module rtp_jpeg_packetizer_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  jpeg_byte_i,
  input  logic [23:0] frame_length_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  out_byte_o,
  output logic        packet_end_o,
  output logic        item_end_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  rjp_pkg::cfg_t  cfg;
  rjp_pkg::emit_t emit;
  logic           load_ok;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  rjp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  rjp_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .jpeg_byte_i    (jpeg_byte_i),
    .frame_length_i (frame_length_i),
    .load_ok_i      (load_ok),
    .emit_o         (emit)
  );

  rjp_out_reg u_out (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .emit_i       (emit),
    .load_ok_o    (load_ok),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_byte_o   (out_byte_o),
    .packet_end_o (packet_end_o),
    .item_end_o   (item_end_o)
  );

endmodule

### hdl/rjp_cfg_regs.sv
// ---------------------------------------------------------------------------
// rjp_cfg_regs
// Configuration register file written through the cfg channel
// ---------------------------------------------------------------------------
module rjp_cfg_regs (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cfg_valid_i,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i,
  output rjp_pkg::cfg_t cfg_o
);

  rjp_pkg::cfg_t      cfg_q;
  rjp_pkg::cfg_index_e idx;

  assign idx   = rjp_pkg::cfg_index_e'(cfg_index_i);
  assign cfg_o = cfg_q;

  // register writes, one per transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_fragment    <= rjp_pkg::Max_Fragment_Rst;
      cfg_q.tcp_interleaved <= rjp_pkg::Tcp_Rst;
      cfg_q.width_blocks    <= rjp_pkg::Width_Rst;
      cfg_q.height_blocks   <= rjp_pkg::Height_Rst;
      cfg_q.timestamp_step  <= rjp_pkg::Ts_Step_Rst;
      cfg_q.ssrc            <= rjp_pkg::Ssrc_Rst;
      cfg_q.quality_factor  <= rjp_pkg::Quality_Rst;
      cfg_q.jpeg_type       <= rjp_pkg::Jpeg_Type_Rst;
    end else if (cfg_valid_i) begin
      unique case (idx)
        rjp_pkg::Cfg_Max_Fragment:   cfg_q.max_fragment    <= cfg_data_i[10:0];
        rjp_pkg::Cfg_Tcp_Interleave: cfg_q.tcp_interleaved <= cfg_data_i[0];
        rjp_pkg::Cfg_Width_Blocks:   cfg_q.width_blocks    <= cfg_data_i[7:0];
        rjp_pkg::Cfg_Height_Blocks:  cfg_q.height_blocks   <= cfg_data_i[7:0];
        rjp_pkg::Cfg_Ts_Step:        cfg_q.timestamp_step  <= cfg_data_i[16:0];
        rjp_pkg::Cfg_Ssrc:           cfg_q.ssrc            <= cfg_data_i;
        rjp_pkg::Cfg_Quality:        cfg_q.quality_factor  <= cfg_data_i[7:0];
        rjp_pkg::Cfg_Jpeg_Type:      cfg_q.jpeg_type       <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

endmodule

### hdl/rjp_core.sv
// ---------------------------------------------------------------------------
// rjp_core
// Input register, packet state and header sequencing; while not stalled, one byte out per cycle
// ---------------------------------------------------------------------------
module rjp_core (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rjp_pkg::cfg_t  cfg_i,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  logic [7:0]     jpeg_byte_i,
  input  logic [23:0]    frame_length_i,
  input  logic           load_ok_i,
  output rjp_pkg::emit_t emit_o
);

  // held input item
  logic        held_q;
  logic [7:0]  byte_q;
  logic [23:0] flen_q;

  // packet state
  logic [15:0] seq_q;
  logic [31:0] ts_q;
  logic [23:0] off_q;
  logic [10:0] left_q;

  // header sequencing and fragment decision taken at header start
  logic [4:0]  cnt_q;
  logic [10:0] frag_q;
  logic        last_q;
  logic [23:0] offe_q;

  logic [23:0] flen_eff;
  logic        new_frag;
  logic [4:0]  pos;
  logic        at_payload;
  logic        emit;
  logic        finish;
  logic [23:0] off_now;
  logic [23:0] rem;
  logic [10:0] mf;
  logic        mf_lt;
  logic [10:0] frag_c;
  logic [11:0] psize;
  logic [7:0]  hdr_byte;
  logic [10:0] base_left;
  logic [23:0] base_off;
  logic [10:0] left_n;
  logic [23:0] off_n;
  logic        frame_done;

  assign flen_eff   = (flen_q == 24'd0) ? 24'd1 : flen_q;
  assign new_frag   = (left_q == 11'd0);
  assign pos        = cnt_q + (cfg_i.tcp_interleaved ? 5'd0 : rjp_pkg::Pos_Rtp_Start);
  assign at_payload = !new_frag || (pos == rjp_pkg::Pos_Payload);
  assign emit       = held_q && load_ok_i;
  assign finish     = emit && at_payload;
  assign in_ready_o = !held_q || finish;

  // fragment size decision, stale offset restarts the frame
  assign off_now = (off_q >= flen_eff) ? 24'd0 : off_q;
  assign rem     = flen_eff - off_now;
  assign mf      = (cfg_i.max_fragment == 11'd0) ? 11'd1 : cfg_i.max_fragment;
  assign mf_lt   = ({13'd0, mf} < rem);
  assign frag_c  = mf_lt ? mf : rem[10:0];
  assign psize   = {1'b0, frag_q} + rjp_pkg::Hdr_Overhead;

  // header byte at the current position
  always_comb begin
    case (pos)
      5'd0:    hdr_byte = rjp_pkg::Interleave_Magic;
      5'd1:    hdr_byte = 8'h00;
      5'd2:    hdr_byte = {4'h0, psize[11:8]};
      5'd3:    hdr_byte = psize[7:0];
      5'd4:    hdr_byte = rjp_pkg::Rtp_First_Byte;
      5'd5:    hdr_byte = {last_q, rjp_pkg::Rtp_Payload_Type};
      5'd6:    hdr_byte = seq_q[15:8];
      5'd7:    hdr_byte = seq_q[7:0];
      5'd8:    hdr_byte = ts_q[31:24];
      5'd9:    hdr_byte = ts_q[23:16];
      5'd10:   hdr_byte = ts_q[15:8];
      5'd11:   hdr_byte = ts_q[7:0];
      5'd12:   hdr_byte = cfg_i.ssrc[31:24];
      5'd13:   hdr_byte = cfg_i.ssrc[23:16];
      5'd14:   hdr_byte = cfg_i.ssrc[15:8];
      5'd15:   hdr_byte = cfg_i.ssrc[7:0];
      5'd16:   hdr_byte = 8'h00;
      5'd17:   hdr_byte = offe_q[23:16];
      5'd18:   hdr_byte = offe_q[15:8];
      5'd19:   hdr_byte = offe_q[7:0];
      5'd20:   hdr_byte = cfg_i.jpeg_type;
      5'd21:   hdr_byte = cfg_i.quality_factor;
      5'd22:   hdr_byte = cfg_i.width_blocks;
      5'd23:   hdr_byte = cfg_i.height_blocks;
      default: hdr_byte = 8'h00;
    endcase
  end

  // payload byte bookkeeping
  assign base_left  = new_frag ? frag_q : left_q;
  assign base_off   = new_frag ? offe_q : off_q;
  assign left_n     = base_left - 11'd1;
  assign off_n      = base_off + 24'd1;
  assign frame_done = (left_n == 11'd0) && ((off_n >= flen_eff) || (off_n == 24'd0));

  assign emit_o.valid      = emit;
  assign emit_o.out_byte   = at_payload ? byte_q : hdr_byte;
  assign emit_o.packet_end = at_payload && (left_n == 11'd0);
  assign emit_o.item_end   = at_payload;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= 1'b0;
    end else if (in_ready_o) begin
      held_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      byte_q <= jpeg_byte_i;
      flen_q <= frame_length_i;
    end
  end

  // fragment decision registered with the first header byte
  always_ff @(posedge clk_i) begin
    if (emit && new_frag && (cnt_q == 5'd0)) begin
      frag_q <= frag_c;
      last_q <= !mf_lt;
      offe_q <= off_now;
    end
  end

  // packet state and header counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_q  <= 16'd0;
      ts_q   <= 32'd0;
      off_q  <= 24'd0;
      left_q <= 11'd0;
      cnt_q  <= 5'd0;
    end else if (finish) begin
      left_q <= left_n;
      off_q  <= frame_done ? 24'd0 : off_n;
      cnt_q  <= 5'd0;
      if (frame_done) begin
        ts_q <= ts_q + {15'd0, cfg_i.timestamp_step};
      end
      if (new_frag) begin
        seq_q <= seq_q + 16'd1;
      end
    end else if (emit) begin
      cnt_q <= cnt_q + 5'd1;
    end
  end

endmodule

### hdl/rjp_out_reg.sv
// ---------------------------------------------------------------------------
// rjp_out_reg
// Result register between the core and the output channel
// ---------------------------------------------------------------------------
module rjp_out_reg (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  rjp_pkg::emit_t emit_i,
  output logic           load_ok_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     out_byte_o,
  output logic           packet_end_o,
  output logic           item_end_o
);

  logic       valid_q;
  logic [7:0] byte_q;
  logic       pend_q;
  logic       iend_q;

  // free when empty or emptied by a transfer this cycle
  assign load_ok_o = !valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_ok_o) begin
      valid_q <= emit_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_ok_o && emit_i.valid) begin
      byte_q <= emit_i.out_byte;
      pend_q <= emit_i.packet_end;
      iend_q <= emit_i.item_end;
    end
  end

  assign out_valid_o  = valid_q;
  assign out_byte_o   = byte_q;
  assign packet_end_o = pend_q;
  assign item_end_o   = iend_q;

endmodule

### hdl/rjp_port_checker.sv
// ---------------------------------------------------------------------------
// rjp_port_checker
// Port-level checks of the packetizer, bound to the top level
// ---------------------------------------------------------------------------
`include "rtp_jpeg_packetizer_top_assert.svh"

module rjp_port_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_o,
  input logic out_valid_o,
  input logic out_ready_i,
  input logic packet_end_o,
  input logic item_end_o
);

  // a stalled result stays offered
  `RJP_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o, clk_i, rst_ni)

  // the last byte of a packet is always a payload byte, which ends its item
  `RJP_ASSERT_NOW(a_pend_iend, out_valid_o && packet_end_o, item_end_o, clk_i, rst_ni)

  // input back-pressure only while the core has a byte for the output
  `RJP_ASSERT_NEXT(a_busy_out, !in_ready_o, out_valid_o, clk_i, rst_ni)

endmodule

bind rtp_jpeg_packetizer_top rjp_port_checker u_port_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_ready_o   (in_ready_o),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .packet_end_o (packet_end_o),
  .item_end_o   (item_end_o)
);
